// File: rtl/prbm_pkg.sv
package prbm_pkg;

    localparam int MAX_PAGES      = 16;
    localparam int PAGE_IDX_W     = $clog2(MAX_PAGES);
    localparam int MAX_PAGE_SHIFT = 24;
    localparam int OP_W           = 3;
    localparam int LEN_W          = 25;
    localparam int SEQ_W          = 64;
    localparam int OFF_W          = 28;
    localparam int STATUS_W       = 2;
    localparam int SHIFT_W        = 5;
    localparam int PCOUNT_W       = 3;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 5;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SHIFT_W-1:0]    RESET_SIZE_SHIFT  = SHIFT_W'(23);
    localparam logic [PCOUNT_W-1:0]   RESET_COUNT_SHIFT = PCOUNT_W'(4);
    localparam logic [LEN_W-1:0]      COUNT_MAX         = '1;

    typedef enum logic [OP_W-1:0] {
        OP_RESERVE     = 3'd0,
        OP_COMMIT      = 3'd1,
        OP_RELEASE_SEQ = 3'd2,
        OP_RELEASE_OFF = 3'd3,
        OP_LOCATE      = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BUSY     = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAGE_SIZE_SHIFT  = 1'b0,
        CFG_PAGE_COUNT_SHIFT = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        K_NONE,
        K_RESERVE,
        K_COMMIT,
        K_RELEASE,
        K_LOCATE
    } kind_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_UPD_FIRST,
        BS_UPD_SECOND
    } back_state_t;

    // Effective geometry derived from the two configuration registers.
    typedef struct packed {
        logic [SHIFT_W-1:0]    sh;
        logic [LEN_W-1:0]      psize;
        logic [PAGE_IDX_W-1:0] pmask;
    } cfg_t;

    // A classified word as it waits between the front and back parts.
    typedef struct packed {
        kind_t                 kind;
        logic [LEN_W-1:0]      len;
        logic [SEQ_W-1:0]      seq;
        logic [PAGE_IDX_W-1:0] i1;
        logic [PAGE_IDX_W-1:0] i2;
        logic                  two;
        logic [LEN_W-1:0]      a1;
        logic [LEN_W-1:0]      a2;
        logic [OFF_W-1:0]      loc_offset;
        logic [LEN_W-1:0]      loc_avail;
    } item_t;

    function automatic cfg_t make_cfg(input logic [SHIFT_W-1:0] size_shift,
                                      input logic [PCOUNT_W-1:0] count_shift);
        cfg_t                c;
        logic [SHIFT_W-1:0]  s;
        logic [PCOUNT_W-1:0] p;
        s = size_shift;
        if (s < SHIFT_W'(1)) s = SHIFT_W'(1);
        if (s > SHIFT_W'(MAX_PAGE_SHIFT)) s = SHIFT_W'(MAX_PAGE_SHIFT);
        p = count_shift;
        if (p > PCOUNT_W'(PAGE_IDX_W)) p = PCOUNT_W'(PAGE_IDX_W);
        c.sh    = s;
        c.psize = LEN_W'(1) << s;
        c.pmask = ~({PAGE_IDX_W{1'b1}} << p);
        return c;
    endfunction

endpackage

// File: rtl/prbm_in_if.sv
interface prbm_in_if;
    import prbm_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [LEN_W-1:0]    length;
    logic [SEQ_W-1:0]    stream_seq;
    logic [OFF_W-1:0]    buffer_offset;

    modport source(output valid, output operation, output length, output stream_seq,
                   output buffer_offset, input ready);
    modport sink(input valid, input operation, input length, input stream_seq,
                 input buffer_offset, output ready);
endinterface

// File: rtl/prbm_out_if.sv
interface prbm_out_if;
    import prbm_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    offset;
    logic [LEN_W-1:0]    avail_length;
    logic [SEQ_W-1:0]    committed_seq;
    logic                ready_res;

    modport source(output valid, output status, output offset, output avail_length,
                   output committed_seq, output ready_res, input ready);
    modport sink(input valid, input status, input offset, input avail_length,
                 input committed_seq, input ready_res, output ready);
endinterface

// File: rtl/paged_ring_buffer_manager.sv
// Paged ring buffer manager: bookkeeping for one byte stream kept in a ring
// of equal pages. Words arrive on req (operation, length, stream_seq,
// buffer_offset) and each produces exactly one word on rsp (status, offset,
// avail_length, committed_seq, ready_res). Both channels move a word when
// valid and ready are high together at a rising clock edge.
// The page geometry is set through cfg_we/cfg_index/cfg_data; index 0 is the
// page size shift, index 1 the page count shift. Write them only while no
// word is in flight.
// Reserve, commit, locate and unknown operations pass through the queue and
// the output register and sustain one word per cycle while rsp is not
// stalled and no release is in progress. A release reads its page count
// through the registered read port of the count memory and updates it in
// the following state, and again for the second page when it spans two.
// A two-entry queue sits between the classifying front and the executing
// back, and the result sits in an output register, so req keeps taking words
// while rsp is stalled until the queue fills; rsp holds its word until taken.
// Reset clears the write position, sequence counter and all page counts, marks
// page zero in use and loads the default geometry; no clearing pass is needed.
module paged_ring_buffer_manager (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [prbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prbm_pkg::CFG_DATA_W-1:0] cfg_data,
    prbm_in_if.sink                         req,
    prbm_out_if.source                      rsp
);
    import prbm_pkg::*;

    logic [SHIFT_W-1:0]  size_shift_reg, size_shift_next;
    logic [PCOUNT_W-1:0] count_shift_reg, count_shift_next;
    cfg_t                cfg;

    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    item_t               q_item;
    item_t               q_head;

    // Configuration writes land directly in the two geometry registers.
    always_comb
    begin
        size_shift_next  = size_shift_reg;
        count_shift_next = count_shift_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PAGE_SIZE_SHIFT:  size_shift_next  = cfg_data[SHIFT_W-1:0];
                CFG_PAGE_COUNT_SHIFT: count_shift_next = cfg_data[PCOUNT_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_shift_reg  <= RESET_SIZE_SHIFT;
            count_shift_reg <= RESET_COUNT_SHIFT;
        end
        else
        begin
            size_shift_reg  <= size_shift_next;
            count_shift_reg <= count_shift_next;
        end
    end

    // Out-of-range shifts are clamped here once for both parts.
    assign cfg = make_cfg(size_shift_reg, count_shift_reg);

    prbm_front u_front (
        .cfg    (cfg),
        .req    (req),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_item)
    );

    prbm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    prbm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

    // The back part never takes a word from an empty queue.
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // Busy and overflow results carry no offset and no length.
    a_err_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> (rsp.offset == '0 && rsp.avail_length == '0))
        else $error("error result carries offset or length");

    // Nothing is offered on rsp once reset has been seen.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !rsp.valid)
        else $error("rsp valid during reset");

endmodule

// File: rtl/prbm_front.sv
module prbm_front (
    input  prbm_pkg::cfg_t  cfg,
    prbm_in_if.sink         req,
    input  logic            q_full,
    output logic            q_push,
    output prbm_pkg::item_t q_item
);
    import prbm_pkg::*;

    logic [OFF_W-1:0]      lo;
    logic [OFF_W-1:0]      end_lo;
    logic [OFF_W-1:0]      ringmask;
    logic [LEN_W-1:0]      pofs_mask;
    logic [LEN_W-1:0]      a_first;
    logic [LEN_W-1:0]      a_last;
    logic [PAGE_IDX_W-1:0] seq_page;
    logic [PAGE_IDX_W-1:0] end_page;
    logic [PAGE_IDX_W-1:0] off_page;

    assign req.ready = !q_full;
    assign q_push    = req.valid && !q_full;

    // Only the low ring bits of a sequence matter for page and offset math.
    assign lo        = req.stream_seq[OFF_W-1:0];
    assign end_lo    = lo + OFF_W'(req.length) - OFF_W'(1);
    assign pofs_mask = cfg.psize - LEN_W'(1);
    assign ringmask  = (OFF_W'(cfg.pmask) << cfg.sh) | OFF_W'(pofs_mask);
    assign a_first   = cfg.psize - (lo[LEN_W-1:0] & pofs_mask);
    assign a_last    = (end_lo[LEN_W-1:0] & pofs_mask) + LEN_W'(1);
    assign seq_page  = PAGE_IDX_W'(lo >> cfg.sh) & cfg.pmask;
    assign end_page  = PAGE_IDX_W'(end_lo >> cfg.sh) & cfg.pmask;
    assign off_page  = PAGE_IDX_W'(req.buffer_offset >> cfg.sh) & cfg.pmask;

    always_comb
    begin
        q_item      = '0;
        q_item.kind = K_NONE;
        q_item.len  = req.length;
        q_item.seq  = req.stream_seq;
        case (op_t'(req.operation))
            OP_RESERVE:
            begin
                q_item.kind = K_RESERVE;
            end
            OP_COMMIT:
            begin
                q_item.kind = K_COMMIT;
            end
            OP_RELEASE_SEQ:
            begin
                // A zero-length release touches nothing and answers like a no-op.
                if (req.length != '0)
                begin
                    q_item.kind = K_RELEASE;
                    q_item.i1   = seq_page;
                    q_item.i2   = end_page;
                    q_item.two  = (seq_page != end_page);
                    q_item.a1   = (seq_page != end_page) ? a_first : req.length;
                    q_item.a2   = a_last;
                end
            end
            OP_RELEASE_OFF:
            begin
                q_item.kind = K_RELEASE;
                q_item.i1   = off_page;
                q_item.i2   = off_page;
                q_item.two  = 1'b0;
                q_item.a1   = req.length;
                q_item.a2   = req.length;
            end
            OP_LOCATE:
            begin
                q_item.kind       = K_LOCATE;
                q_item.loc_offset = lo & ringmask;
                // The length is clipped only on the last page of the ring.
                if (seq_page == cfg.pmask && a_first < req.length)
                    q_item.loc_avail = a_first;
                else
                    q_item.loc_avail = req.length;
            end
            default:
            begin
                q_item.kind = K_NONE;
            end
        endcase
    end

endmodule

// File: rtl/prbm_queue.sv
module prbm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  prbm_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output prbm_pkg::item_t head,
    output logic            empty
);
    import prbm_pkg::*;

    item_t             slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// File: rtl/prbm_back.sv
module prbm_back (
    input  logic            clk,
    input  logic            rst_n,
    input  prbm_pkg::cfg_t  cfg,
    input  logic            q_empty,
    input  prbm_pkg::item_t q_head,
    output logic            q_pop,
    prbm_out_if.source      rsp
);
    import prbm_pkg::*;

    typedef struct packed {
        logic [LEN_W-1:0] value;
        logic             free;
        logic             over;
    } upd_t;

    function automatic upd_t upd_count(input logic [LEN_W-1:0] rel,
                                       input logic [LEN_W-1:0] amt,
                                       input logic [LEN_W-1:0] psize);
        upd_t           u;
        logic [LEN_W:0] sum;
        logic [LEN_W-1:0] sat;
        sum     = {1'b0, rel} + {1'b0, amt};
        sat     = sum[LEN_W] ? COUNT_MAX : sum[LEN_W-1:0];
        u.over  = (sat > psize);
        u.free  = (sat == psize);
        u.value = u.free ? '0 : sat;
        return u;
    endfunction

    back_state_t           state_reg, state_next;
    logic [PAGE_IDX_W-1:0] write_page_reg, write_page_next;
    logic [LEN_W-1:0]      write_pos_reg, write_pos_next;
    logic [SEQ_W-1:0]      seq_count_reg, seq_count_next;
    logic [MAX_PAGES-1:0]  in_use_reg, in_use_next;
    logic [MAX_PAGES-1:0]  rel_valid_reg, rel_valid_next;
    logic [LEN_W-1:0]      rel_mem [MAX_PAGES];
    logic [LEN_W-1:0]      rd_data_reg;
    logic                  rd_valid_reg;
    item_t                 item_reg, item_next;
    logic                  err_reg, err_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [OFF_W-1:0]      out_offset_reg, out_offset_next;
    logic [LEN_W-1:0]      out_avail_reg, out_avail_next;
    logic [SEQ_W-1:0]      out_seq_reg, out_seq_next;
    logic                  out_ready_reg, out_ready_next;

    logic                  out_free;
    logic                  load_out;
    logic [SEQ_W-1:0]      cmp_seq;
    logic [PAGE_IDX_W-1:0] rd_addr;
    logic                  mem_we;
    logic [PAGE_IDX_W-1:0] mem_wa;
    logic [LEN_W-1:0]      mem_wd;
    logic [LEN_W-1:0]      rel_cur;
    upd_t                  upd;
    logic [PAGE_IDX_W-1:0] cur_page;
    logic [PAGE_IDX_W-1:0] nxt_page;
    logic [LEN_W:0]        pos_sum;

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.offset        = out_offset_reg;
    assign rsp.avail_length  = out_avail_reg;
    assign rsp.committed_seq = out_seq_reg;
    assign rsp.ready_res     = out_ready_reg;

    assign out_free = !out_valid_reg || rsp.ready;
    assign rel_cur  = rd_valid_reg ? rd_data_reg : '0;
    assign cur_page = write_page_reg & cfg.pmask;
    assign nxt_page = (cur_page + PAGE_IDX_W'(1)) & cfg.pmask;
    assign pos_sum  = {1'b0, write_pos_reg} + {1'b0, q_head.len};

    always_comb
    begin
        state_next      = state_reg;
        write_page_next = write_page_reg;
        write_pos_next  = write_pos_reg;
        seq_count_next  = seq_count_reg;
        in_use_next     = in_use_reg;
        rel_valid_next  = rel_valid_reg;
        item_next       = item_reg;
        err_next        = err_reg;
        q_pop           = 1'b0;
        load_out        = 1'b0;
        cmp_seq         = q_head.seq;
        rd_addr         = q_head.i1;
        mem_we          = 1'b0;
        mem_wa          = item_reg.i1;
        mem_wd          = '0;
        upd             = upd_count(rel_cur, item_reg.a1, cfg.psize);
        out_status_next = ST_OK;
        out_offset_next = '0;
        out_avail_next  = '0;

        case (state_reg)
            BS_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    q_pop = 1'b1;
                    case (q_head.kind)
                        K_RESERVE:
                        begin
                            load_out = 1'b1;
                            if (write_pos_reg >= cfg.psize)
                            begin
                                if (in_use_reg[nxt_page])
                                begin
                                    out_status_next = ST_BUSY;
                                end
                                else
                                begin
                                    in_use_next[nxt_page] = 1'b1;
                                    write_page_next       = nxt_page;
                                    write_pos_next        = '0;
                                    out_offset_next       = OFF_W'(nxt_page) << cfg.sh;
                                    out_avail_next        = cfg.psize;
                                end
                            end
                            else
                            begin
                                write_page_next = cur_page;
                                out_offset_next = (OFF_W'(cur_page) << cfg.sh)
                                                + OFF_W'(write_pos_reg);
                                out_avail_next  = cfg.psize - write_pos_reg;
                            end
                        end
                        K_COMMIT:
                        begin
                            load_out       = 1'b1;
                            seq_count_next = seq_count_reg + SEQ_W'(q_head.len);
                            write_pos_next = (pos_sum > {1'b0, cfg.psize}) ? cfg.psize
                                                                           : pos_sum[LEN_W-1:0];
                        end
                        K_LOCATE:
                        begin
                            load_out        = 1'b1;
                            out_offset_next = q_head.loc_offset;
                            out_avail_next  = q_head.loc_avail;
                        end
                        K_RELEASE:
                        begin
                            // The first page count is read now and updated next cycle.
                            item_next  = q_head;
                            err_next   = 1'b0;
                            state_next = BS_UPD_FIRST;
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            BS_UPD_FIRST:
            begin
                cmp_seq = item_reg.seq;
                upd     = upd_count(rel_cur, item_reg.a1, cfg.psize);
                mem_we  = 1'b1;
                mem_wa  = item_reg.i1;
                mem_wd  = upd.value;
                rel_valid_next[item_reg.i1] = 1'b1;
                if (upd.free)
                    in_use_next[item_reg.i1] = 1'b0;
                if (item_reg.two)
                begin
                    rd_addr    = item_reg.i2;
                    err_next   = upd.over;
                    state_next = BS_UPD_SECOND;
                end
                else
                begin
                    load_out        = 1'b1;
                    out_status_next = upd.over ? ST_OVERFLOW : ST_OK;
                    state_next      = BS_IDLE;
                end
            end
            BS_UPD_SECOND:
            begin
                cmp_seq = item_reg.seq;
                upd     = upd_count(rel_cur, item_reg.a2, cfg.psize);
                mem_we  = 1'b1;
                mem_wa  = item_reg.i2;
                mem_wd  = upd.value;
                rel_valid_next[item_reg.i2] = 1'b1;
                if (upd.free)
                    in_use_next[item_reg.i2] = 1'b0;
                load_out        = 1'b1;
                out_status_next = (err_reg || upd.over) ? ST_OVERFLOW : ST_OK;
                state_next      = BS_IDLE;
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase

        out_seq_next   = seq_count_next;
        out_ready_next = (seq_count_next >= cmp_seq);

        if (load_out)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BS_IDLE;
            write_page_reg <= '0;
            write_pos_reg  <= '0;
            seq_count_reg  <= '0;
            in_use_reg     <= MAX_PAGES'(1);
            rel_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            write_page_reg <= write_page_next;
            write_pos_reg  <= write_pos_next;
            seq_count_reg  <= seq_count_next;
            in_use_reg     <= in_use_next;
            rel_valid_reg  <= rel_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        err_reg  <= err_next;
        if (load_out)
        begin
            out_status_reg <= out_status_next;
            out_offset_reg <= out_offset_next;
            out_avail_reg  <= out_avail_next;
            out_seq_reg    <= out_seq_next;
            out_ready_reg  <= out_ready_next;
        end
    end

    // Released-byte counts: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            rel_mem[mem_wa] <= mem_wd;
        rd_data_reg  <= rel_mem[rd_addr];
        rd_valid_reg <= rel_valid_reg[rd_addr];
    end

endmodule

// File: test/paged_ring_buffer_manager_tb.sv
module paged_ring_buffer_manager_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prbm_pkg::*;

    // One request word as the testbench sees it.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [LEN_W-1:0] len;
        logic [SEQ_W-1:0] seq;
        logic [OFF_W-1:0] boff;
    } req_word_t;

    // One response word, field for field as it leaves the block.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    offset;
        logic [LEN_W-1:0]    avail;
        logic [SEQ_W-1:0]    cseq;
        logic                rdy;
    } rsp_word_t;

    typedef enum logic {
        ROW_SEND,
        ROW_CONFIG
    } row_kind_t;

    // A row of the directed script: either a request word (with an optional
    // hand-written response) or a register write.
    typedef struct packed {
        row_kind_t               kind;
        cfg_idx_t                idx;
        logic [CFG_DATA_W-1:0]   val;
        req_word_t               w;
        logic                    known;
        rsp_word_t               exp;
    } row_t;

    localparam int          DIR_ROWS        = 25;
    localparam int          N_PHASES        = 10;
    localparam int          ITEMS_PER_PHASE = 143;
    localparam int          TAIL_CYCLES     = 4;
    localparam int          WATCHDOG_LIMIT  = 2000;
    localparam logic [63:0] PG              = 64'd8388608;
    localparam logic [OP_W-1:0] OP_UNUSED   = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    prbm_in_if  req_ch ();
    prbm_out_if rsp_ch ();

    paged_ring_buffer_manager dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Shadow copy of the block's registers and page bookkeeping. The
    // predictor below works on these and nothing else.
    logic [SHIFT_W-1:0]    cfg_size_shift;
    logic [PCOUNT_W-1:0]   cfg_count_shift;
    logic [PAGE_IDX_W-1:0] wr_page;
    logic [LEN_W-1:0]      wr_pos;
    logic [SEQ_W-1:0]      seq_total;
    logic                  pg_busy  [MAX_PAGES];
    logic [LEN_W-1:0]      pg_freed [MAX_PAGES];

    // Responses the block still owes us, oldest first.
    rsp_word_t awaited_rsp [$];

    // Stimulus-side bookkeeping: how far the stream has been handed back.
    logic [SEQ_W-1:0] free_mark;

    row_t                  script      [DIR_ROWS];
    logic [CFG_DATA_W-1:0] phase_size  [N_PHASES];
    logic [CFG_DATA_W-1:0] phase_count [N_PHASES];

    bit calm;
    int mismatches = 0;
    int idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // The page size shift is clamped into 1..MAX_PAGE_SHIFT.
    function automatic int unsigned geo_shift();
        int unsigned s;
        s = cfg_size_shift;
        if (s < 1) s = 1;
        if (s > MAX_PAGE_SHIFT) s = MAX_PAGE_SHIFT;
        return s;
    endfunction

    // The page count shift is walked down until the ring fits in the table.
    function automatic int unsigned geo_pages();
        int unsigned s;
        s = cfg_count_shift;
        while (s > 0 && (1 << s) > MAX_PAGES) s--;
        return 1 << s;
    endfunction

    task automatic ring_reset();
        cfg_size_shift  = RESET_SIZE_SHIFT;
        cfg_count_shift = RESET_COUNT_SHIFT;
        wr_page   = '0;
        wr_pos    = '0;
        seq_total = '0;
        free_mark = '0;
        for (int i = 0; i < MAX_PAGES; i++)
        begin
            pg_busy[i]  = 1'b0;
            pg_freed[i] = '0;
        end
        pg_busy[0] = 1'b1;
    endtask

    // Released-byte counts saturate at the top of their 25 bits.
    function automatic void add_freed(input int unsigned idx, input logic [63:0] n);
        logic [63:0] v;
        v = 64'(pg_freed[idx]) + n;
        pg_freed[idx] = (v > 64'(COUNT_MAX)) ? COUNT_MAX : LEN_W'(v);
    endfunction

    // A page whose count reaches exactly one page is freed; a count past a
    // full page is an overflow and the page is left as it is.
    function automatic bit page_done(input int unsigned idx, input logic [63:0] psize);
        if (64'(pg_freed[idx]) > psize) return 1'b1;
        if (64'(pg_freed[idx]) == psize)
        begin
            pg_freed[idx] = '0;
            pg_busy[idx]  = 1'b0;
        end
        return 1'b0;
    endfunction

    // Applies one accepted request word to the shadow state and returns the
    // response the block must produce for it.
    function automatic rsp_word_t ring_step(input req_word_t w);
        rsp_word_t   r;
        int unsigned sh, pages, pmask, cur, nxt, i1, i2;
        logic [63:0] psize, pos, v, endseq, rest, ringmask;
        bit          busy, err;
        sh    = geo_shift();
        pages = geo_pages();
        pmask = pages - 1;
        psize = 64'd1 << sh;
        r     = '0;
        case (w.op)
            OP_RESERVE:
            begin
                // A stale write page from a wider ring is taken modulo the ring.
                cur  = wr_page & pmask;
                pos  = 64'(wr_pos);
                busy = 1'b0;
                if (pos >= psize)
                begin
                    nxt = (cur + 1) & pmask;
                    if (pg_busy[nxt])
                        busy = 1'b1;
                    else
                    begin
                        cur = nxt;
                        pos = '0;
                        pg_busy[nxt] = 1'b1;
                    end
                end
                if (busy)
                    r.status = ST_BUSY;
                else
                begin
                    wr_page  = PAGE_IDX_W'(cur);
                    wr_pos   = LEN_W'(pos);
                    r.offset = OFF_W'((64'(cur) << sh) + pos);
                    r.avail  = LEN_W'(psize - pos);
                end
            end
            OP_COMMIT:
            begin
                v         = 64'(wr_pos) + 64'(w.len);
                seq_total = seq_total + 64'(w.len);
                wr_pos    = (v > psize) ? LEN_W'(psize) : LEN_W'(v);
            end
            OP_RELEASE_SEQ:
            begin
                if (w.len != '0)
                begin
                    endseq = w.seq + 64'(w.len) - 64'd1;
                    i1 = 32'((w.seq >> sh) & 64'(pmask));
                    i2 = 32'((endseq >> sh) & 64'(pmask));
                    if (i1 == i2)
                    begin
                        add_freed(i1, 64'(w.len));
                        err = page_done(i1, psize);
                    end
                    else
                    begin
                        // Only the two end pages of the span are credited.
                        add_freed(i1, psize - (w.seq & (psize - 64'd1)));
                        add_freed(i2, (endseq & (psize - 64'd1)) + 64'd1);
                        err = page_done(i1, psize);
                        if (page_done(i2, psize)) err = 1'b1;
                    end
                    if (err) r.status = ST_OVERFLOW;
                end
            end
            OP_RELEASE_OFF:
            begin
                i1 = 32'((64'(w.boff) >> sh) & 64'(pmask));
                add_freed(i1, 64'(w.len));
                if (page_done(i1, psize)) r.status = ST_OVERFLOW;
            end
            OP_LOCATE:
            begin
                i1       = 32'((w.seq >> sh) & 64'(pmask));
                ringmask = (64'(pages) << sh) - 64'd1;
                r.avail  = w.len;
                // Only the last page of the ring clips the length.
                if (i1 == pmask)
                begin
                    rest = psize - (w.seq & (psize - 64'd1));
                    if (rest < 64'(w.len)) r.avail = LEN_W'(rest);
                end
                r.offset = OFF_W'(w.seq & ringmask);
            end
            default:
            begin
            end
        endcase
        r.cseq = seq_total;
        r.rdy  = (seq_total >= w.seq);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed script helpers
    // ------------------------------------------------------------------

    function automatic row_t op_row(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] len,
                                    input logic [SEQ_W-1:0] seq,
                                    input logic [OFF_W-1:0] boff);
        row_t r;
        r      = '0;
        r.kind = ROW_SEND;
        r.w    = '{op, len, seq, boff};
        return r;
    endfunction

    function automatic row_t chk_row(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] len,
                                     input logic [SEQ_W-1:0] seq,
                                     input logic [OFF_W-1:0] boff,
                                     input logic [STATUS_W-1:0] st,
                                     input logic [OFF_W-1:0] off,
                                     input logic [LEN_W-1:0] av,
                                     input logic [SEQ_W-1:0] cs, input logic rdy);
        row_t r;
        r       = op_row(op, len, seq, boff);
        r.known = 1'b1;
        r.exp   = '{st, off, av, cs, rdy};
        return r;
    endfunction

    function automatic row_t cfg_row(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        row_t r;
        r      = '0;
        r.kind = ROW_CONFIG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random word source
    // ------------------------------------------------------------------

    // Most words follow a plausible producer/consumer pattern: reserve, fill
    // the page with commits, hand bytes back by sequence or by page, and
    // look up recent sequences. The remaining fifth is unconstrained noise.
    function automatic req_word_t draw_word();
        req_word_t   w;
        int unsigned sh, pages, idx, pick;
        logic [63:0] psize, room, span, cap;
        sh    = geo_shift();
        pages = geo_pages();
        psize = 64'd1 << sh;
        if (free_mark > seq_total) free_mark = seq_total;
        w.op   = OP_RESERVE;
        w.len  = '0;
        w.seq  = seq_total + 64'($urandom_range(0, 4)) - 64'd2;
        w.boff = OFF_W'($urandom);
        pick   = $urandom_range(0, 99);
        if (pick >= 80)
        begin
            w.op  = OP_W'($urandom_range(0, 7));
            w.len = ($urandom_range(0, 1) != 0) ? LEN_W'($urandom)
                                                : LEN_W'($urandom_range(0, 32'(2 * psize)));
            w.seq = {$urandom, $urandom};
        end
        else if (pick < 18)
            w.op = OP_RESERVE;
        else if (pick < 38)
        begin
            // Usually fill the rest of the page, sometimes only part of it.
            w.op  = OP_COMMIT;
            room  = (64'(wr_pos) < psize) ? psize - 64'(wr_pos) : 64'd0;
            w.len = ($urandom_range(0, 2) == 0) ? LEN_W'($urandom_range(0, 32'(room)))
                                                : LEN_W'(room);
        end
        else if (pick < 55)
        begin
            w.op  = OP_RELEASE_SEQ;
            span  = seq_total - free_mark;
            cap   = 64'($urandom_range(1, 32'(2 * psize - 64'd1)));
            if (span > cap) span = cap;
            w.seq = free_mark;
            w.len = LEN_W'(span);
            free_mark = free_mark + span;
        end
        else if (pick < 68)
        begin
            // Aim at one page and, mostly, top its count up to exactly full.
            w.op   = OP_RELEASE_OFF;
            idx    = $urandom_range(0, pages - 1);
            w.boff = OFF_W'((64'(idx) << sh) + 64'($urandom_range(0, 32'(psize - 64'd1))));
            if (64'(pg_freed[idx]) < psize && $urandom_range(0, 3) != 0)
                w.len = LEN_W'(psize - 64'(pg_freed[idx]));
            else
                w.len = LEN_W'($urandom_range(0, 32'(psize)));
        end
        else
        begin
            w.op  = OP_LOCATE;
            w.seq = free_mark + 64'($urandom_range(0, 32'(2 * psize)));
            w.len = LEN_W'($urandom_range(0, 32'(2 * psize - 64'd1)));
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Presents one request word after a random gap, waits for it to be taken
    // and records the response it must cause. A hand-written response, where
    // given, stands in for the predicted one; the shadow state moves anyway.
    task automatic send_word(input req_word_t w, input logic known, input rsp_word_t typed);
        rsp_word_t   predicted;
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.operation     <= w.op;
        req_ch.length        <= w.len;
        req_ch.stream_seq    <= w.seq;
        req_ch.buffer_offset <= w.boff;
        do @(posedge clk); while (!req_ch.ready);
        predicted = ring_step(w);
        awaited_rsp.push_back(known ? typed : predicted);
    endtask

    // Holds the request side idle until every response is in, then lets the
    // longest release path drain before anything else happens.
    task automatic quiesce();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (awaited_rsp.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only while the block is idle, so the shadow
    // copy can take the new value right away.
    task automatic set_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        if (idx == CFG_PAGE_SIZE_SHIFT)
            cfg_size_shift = val;
        else
            cfg_count_shift = val[PCOUNT_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        req_word_t w;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_PAGE_SIZE_SHIFT;
        cfg_data             = '0;
        req_ch.valid         = 1'b0;
        req_ch.operation     = OP_RESERVE;
        req_ch.length        = '0;
        req_ch.stream_seq    = '0;
        req_ch.buffer_offset = '0;
        calm                 = 1'b0;
        ring_reset();

        // Directed script. The first part runs on the reset geometry of
        // sixteen pages of 8 MiB each.
        script = '{
            // Fresh reserve: page zero from its start.
            chk_row(OP_RESERVE, 0, 0, 0, ST_OK, 0, 25'd8388608, 0, 1'b1),
            // Highest sequence lands on the last page and is clipped to one byte.
            chk_row(OP_LOCATE, 25'h1FFFFFF, '1, 0, ST_OK, 28'h7FFFFFF, 1, 0, 1'b0),
            // A commit past the page end pins the write position at the page size.
            chk_row(OP_COMMIT, 25'd16777216, 0, 0, ST_OK, 0, 0, 64'd16777216, 1'b1),
            // Full page: reserve moves on to page one.
            chk_row(OP_RESERVE, 0, 0, 0, ST_OK, 28'd8388608, 25'd8388608,
                    64'd16777216, 1'b1),
            // Zero-byte release changes nothing.
            op_row(OP_RELEASE_SEQ, 0, 5, 0),
            // Releasing all of page zero frees it.
            op_row(OP_RELEASE_SEQ, LEN_W'(PG), 0, 0),
            // One byte too many on page one.
            chk_row(OP_RELEASE_OFF, LEN_W'(PG + 64'd1), 0, OFF_W'(PG), ST_OVERFLOW, 0, 0,
                    64'd16777216, 1'b1),
            // Largest offset wraps to the last page; the count hits its maximum.
            chk_row(OP_RELEASE_OFF, 25'h1FFFFFF, 0, 28'hFFFFFFF, ST_OVERFLOW, 0, 0,
                    64'd16777216, 1'b1),
            // Span over five pages: only the two end pages are credited.
            op_row(OP_RELEASE_SEQ, LEN_W'(3 * PG + 64'd200), 3 * PG - 100, 0),
            // Span over a page boundary, split between two pages.
            op_row(OP_RELEASE_SEQ, 200, 4 * PG - 100, 0),
            // Locate on a page that is not the last one: no clipping.
            op_row(OP_LOCATE, 1000, 5 * PG + 7, 0),
            // Unused operation code: no state change, zeros out.
            chk_row(OP_UNUSED, 25'h1FFFFFF, 0, 28'hFFFFFFF, ST_OK, 0, 0,
                    64'd16777216, 1'b1),
            op_row(OP_COMMIT, LEN_W'(PG), '1, 0),
            // Size shift zero, which is out of range, and a single page.
            cfg_row(CFG_PAGE_SIZE_SHIFT, 5'd0),
            cfg_row(CFG_PAGE_COUNT_SHIFT, 5'd0),
            // The stale write page and position are folded into the new ring.
            op_row(OP_RESERVE, 0, 0, 0),
            op_row(OP_COMMIT, 3, 0, 0),
            // The only page is still in use, so reserve reports busy.
            chk_row(OP_RESERVE, 0, 0, 0, ST_BUSY, 0, 0, 64'd25165827, 1'b1),
            op_row(OP_RELEASE_SEQ, 2, 0, 0),
            // Retried reserve now succeeds.
            op_row(OP_RESERVE, 0, 0, 0),
            // The other out-of-range extremes: both shifts at their top code.
            cfg_row(CFG_PAGE_SIZE_SHIFT, 5'd31),
            cfg_row(CFG_PAGE_COUNT_SHIFT, 5'd7),
            op_row(OP_LOCATE, 25'd16777216, 64'h8000_0000_0000_0000, 0),
            op_row(OP_RELEASE_SEQ, 10, 64'd16777211, 0),
            op_row(OP_RESERVE, 0, 0, 0)
        };

        // Random phases walk through a mix of geometries, extremes included.
        phase_size  = '{5'd2, 5'd0, 5'd3, 5'd31, 5'd4, 5'd1, 5'd24, 5'd5, 5'd2, 5'd6};
        phase_count = '{5'd1, 5'd0, 5'd2, 5'd7,  5'd3, 5'd4, 5'd0,  5'd2, 5'd3, 5'd5};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].kind == ROW_CONFIG)
            begin
                quiesce();
                set_reg(script[i].idx, script[i].val);
            end
            else
                send_word(script[i].w, script[i].known, script[i].exp);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            quiesce();
            set_reg(CFG_PAGE_SIZE_SHIFT, phase_size[ph]);
            set_reg(CFG_PAGE_COUNT_SHIFT, phase_count[ph]);
            // Every fourth phase runs with no idling on either side.
            calm = (ph % 4 == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Now and then the producer stops until all answers are back.
                if ($urandom_range(0, 199) == 0) quiesce();
                w = draw_word();
                send_word(w, 1'b0, '0);
            end
        end

        quiesce();
        if (mismatches == 0 && awaited_rsp.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Response side: random back-pressure, one stall draw per word.
    // ------------------------------------------------------------------

    initial
    begin : response_sink
        int unsigned stall;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 7);
            @(negedge clk);
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    // Every word taken from the response channel is held against the oldest
    // awaited response, field by field.
    always @(posedge clk)
    begin
        rsp_word_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_rsp.size() == 0)
            begin
                $error("response word with nothing awaited");
                mismatches++;
            end
            else
            begin
                e = awaited_rsp.pop_front();
                if (rsp_ch.status !== e.status)
                begin
                    $error("status: expected %0d, actual %0d", e.status, rsp_ch.status);
                    mismatches++;
                end
                if (rsp_ch.offset !== e.offset)
                begin
                    $error("offset: expected %0h, actual %0h", e.offset, rsp_ch.offset);
                    mismatches++;
                end
                if (rsp_ch.avail_length !== e.avail)
                begin
                    $error("avail_length: expected %0h, actual %0h", e.avail,
                           rsp_ch.avail_length);
                    mismatches++;
                end
                if (rsp_ch.committed_seq !== e.cseq)
                begin
                    $error("committed_seq: expected %0h, actual %0h", e.cseq,
                           rsp_ch.committed_seq);
                    mismatches++;
                end
                if (rsp_ch.ready_res !== e.rdy)
                begin
                    $error("ready_res: expected %0d, actual %0d", e.rdy, rsp_ch.ready_res);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a long stretch with no word moving on either channel means
    // the block has hung.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// File: filelist.f
rtl/prbm_pkg.sv
rtl/prbm_in_if.sv
rtl/prbm_out_if.sv
rtl/prbm_front.sv
rtl/prbm_queue.sv
rtl/prbm_back.sv
rtl/paged_ring_buffer_manager.sv
test/paged_ring_buffer_manager_tb.sv
